>>> src/skh_pkg.sv
// Shared types and constants for the string-key hash table.
`timescale 1ns / 1ps
package skh_pkg;
   localparam int DEPTH_DEFAULT = 32;
   localparam int KEY_BYTES_DEFAULT = 8;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int SIZE_W = 6;
   localparam int KEY_W = 64;
   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int HASH_W = 32;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_W-1:0] OP_SET = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   // one classified word handed from front to back
   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [KEY_W-1:0] key;
      logic [DATA_W-1:0] data;
      logic [HASH_W-1:0] hash;
   } job_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0] read_value;
      logic [SIZE_W-1:0] occupied_count;
   } rsp_type;
endpackage

>>> src/skh_front.sv
// Front end: takes request words, canonicalizes key and hashes one byte a cycle.
`timescale 1ns / 1ps
module skh_front import skh_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [OP_W-1:0] req_opcode,
   input  logic [KEY_W-1:0] req_key_chars,
   input  logic [DATA_W-1:0] req_data_value,
   output logic job_valid,
   input  logic job_ready,
   output job_type job
);
   localparam int CNT_W = $clog2(KEY_BYTES + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(KEY_BYTES);

   logic busy_ff, busy_in, done_ff, done_in, stop_ff, stop_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   job_type job_ff, job_in;
   logic [KEY_W-1:0] raw_ff, raw_in;
   logic [7:0] cur;

   assign full = busy_ff | done_ff;
   assign job_valid = done_ff;
   assign job = job_ff;
   assign cur = raw_ff[7:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      stop_in = stop_ff;
      idx_in = idx_ff;
      job_in = job_ff;
      raw_in = raw_ff;
      if (push && !full) begin
         busy_in = 1'b1;
         stop_in = 1'b0;
         idx_in = '0;
         raw_in = req_key_chars;
         job_in.opcode = req_opcode;
         job_in.data = req_data_value;
         job_in.key = '0;
         job_in.hash = '0;
      end else if (busy_ff) begin
         if (idx_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (!stop_ff && cur != 8'd0) begin
               job_in.hash = job_ff.hash * HASH_W'(33) + HASH_W'(cur);
               job_in.key[idx_ff*8 +: 8] = cur;
            end else begin
               stop_in = 1'b1;
            end
            raw_in = raw_ff >> 8;
            idx_in = idx_ff + CNT_W'(1);
         end
      end else if (done_ff && job_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         stop_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         stop_ff <= stop_in;
         idx_ff <= idx_in;
      end
      job_ff <= job_in;
      raw_ff <= raw_in;
   end

   assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("front busy and done at once");
   assert property (@(posedge clock) disable iff (reset) idx_ff <= LAST)
      else $error("byte index overrun");
   assert property (@(posedge clock) disable iff (reset)
      (done_ff && !job_ready) |=> done_ff)
      else $error("classified word dropped");
endmodule

>>> src/skh_queue.sv
// Two-entry queue between front end and probe engine.
`timescale 1ns / 1ps
module skh_queue import skh_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  job_type in_job,
   output logic out_valid,
   input  logic out_ready,
   output job_type out_job
);
   job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
      if (wr) mem_ff[wp_ff] <= in_job;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overrun");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wp_ff == rp_ff))
      else $error("queue pointers disagree when empty");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (wp_ff == rp_ff))
      else $error("queue pointers disagree when full");
endmodule

>>> src/skh_back.sv
// Probe engine: modulo by table size, serial slot scan, table update, result register.
`timescale 1ns / 1ps
module skh_back import skh_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic [SIZE_W-1:0] table_size,
   input  logic job_valid,
   output logic job_ready,
   input  job_type job,
   output logic empty,
   input  logic pop,
   output rsp_type rsp
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SZ_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int MOD_STEPS = HASH_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff;
   job_type job_ff;
   logic [SZ_W-1:0] size_ff;
   logic [HASH_W-1:0] quot_ff;
   logic [SZ_W:0] rem_ff;
   logic [5:0] step_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [CNT_W-1:0] probed_ff;
   logic pass_ff;
   logic found_ff, free_ff;
   logic [IDX_W-1:0] hit_ff, freeslot_ff;
   logic [CNT_W-1:0] count_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
   logic [KEY_W-1:0] rkey_ff;
   logic [VALUE_BITS-1:0] rval_ff;
   logic [VALUE_BITS-1:0] hval_ff;
   logic rsp_full_ff;
   rsp_type rsp_ff;

   logic [SZ_W:0] rem_sh;
   logic [SZ_W-1:0] live;
   logic [IDX_W-1:0] slot_next;
   logic [VALUE_BITS-1:0] wval;
   logic [DATA_W-1:0] rd32;

   assign live = (table_size == '0) ? SZ_W'(1) :
                 (SZ_W'(table_size) > SZ_W'(TABLE_DEPTH)) ? SZ_W'(TABLE_DEPTH) :
                 SZ_W'(table_size);
   assign rem_sh = {rem_ff[SZ_W-1:0], quot_ff[HASH_W-1]};
   assign slot_next = (SZ_W'(slot_ff) + SZ_W'(1) == size_ff) ? '0 : slot_ff + IDX_W'(1);
   assign job_ready = state_ff == S_IDLE && !rsp_full_ff;
   assign empty = !rsp_full_ff;
   assign rsp = rsp_ff;
   assign wval = VALUE_BITS'(job_ff.data);
   assign rd32 = DATA_W'(hval_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         rsp_full_ff <= 1'b0;
      end else begin
         if (rsp_full_ff && pop) rsp_full_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid && !rsp_full_ff) begin
                  job_ff <= job;
                  size_ff <= live;
                  quot_ff <= job.hash;
                  rem_ff <= '0;
                  step_ff <= '0;
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               // restoring division, one quotient bit per cycle
               if (rem_sh >= {1'b0, size_ff}) rem_ff <= rem_sh - {1'b0, size_ff};
               else rem_ff <= rem_sh;
               quot_ff <= quot_ff << 1;
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'(MOD_STEPS - 1)) begin
                  state_ff <= S_READ;
                  probed_ff <= '0;
                  found_ff <= 1'b0;
                  free_ff <= 1'b0;
                  pass_ff <= 1'b0;
               end
            end
            S_READ: begin
               if (!pass_ff) begin
                  slot_ff <= IDX_W'(rem_ff);
                  pass_ff <= 1'b1;
               end
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (valid_ff[slot_ff] && rkey_ff == job_ff.key && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_ff <= slot_ff;
                  hval_ff <= rval_ff;
               end
               if (!valid_ff[slot_ff] && !free_ff) begin
                  free_ff <= 1'b1;
                  freeslot_ff <= slot_ff;
               end
               probed_ff <= probed_ff + CNT_W'(1);
               slot_ff <= slot_next;
               if (SZ_W'(probed_ff) + SZ_W'(1) == size_ff) state_ff <= S_DONE;
               else state_ff <= S_READ;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
               rsp_full_ff <= 1'b1;
               if (job_ff.opcode == OP_INSERT ||
                   (job_ff.opcode == OP_SET && !found_ff)) begin
                  rsp_ff.read_value <= '0;
                  if (SZ_W'(count_ff) >= size_ff || !free_ff) begin
                     rsp_ff.status <= ST_FULL;
                     rsp_ff.occupied_count <= SIZE_W'(count_ff);
                  end else begin
                     rsp_ff.status <= ST_DONE;
                     valid_ff[freeslot_ff] <= 1'b1;
                     count_ff <= count_ff + CNT_W'(1);
                     rsp_ff.occupied_count <= SIZE_W'(count_ff + CNT_W'(1));
                  end
               end else if (job_ff.opcode == OP_UPDATE || job_ff.opcode == OP_SET) begin
                  rsp_ff.status <= found_ff ? ST_DONE : ST_MISSING;
                  rsp_ff.read_value <= '0;
                  rsp_ff.occupied_count <= SIZE_W'(count_ff);
               end else if (job_ff.opcode == OP_LOOKUP || job_ff.opcode == OP_REMOVE) begin
                  if (!found_ff) begin
                     rsp_ff.status <= ST_MISSING;
                     rsp_ff.read_value <= '0;
                     rsp_ff.occupied_count <= SIZE_W'(count_ff);
                  end else begin
                     rsp_ff.status <= ST_DONE;
                     rsp_ff.read_value <= rd32;
                     if (job_ff.opcode == OP_REMOVE) begin
                        valid_ff[hit_ff] <= 1'b0;
                        if (count_ff != '0) begin
                           count_ff <= count_ff - CNT_W'(1);
                           rsp_ff.occupied_count <= SIZE_W'(count_ff - CNT_W'(1));
                        end else begin
                           rsp_ff.occupied_count <= SIZE_W'(count_ff);
                        end
                     end else begin
                        rsp_ff.occupied_count <= SIZE_W'(count_ff);
                     end
                  end
               end else begin
                  // unknown opcode: no change
                  rsp_ff.status <= ST_DONE;
                  rsp_ff.read_value <= '0;
                  rsp_ff.occupied_count <= SIZE_W'(count_ff);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // key and value stores: one registered read, one write
   logic [IDX_W-1:0] raddr;
   logic wr_key, wr_val;
   logic [IDX_W-1:0] waddr;
   // first probe reads the home slot before slot_ff holds it
   assign raddr = (state_ff == S_DONE) ? hit_ff :
                  (state_ff == S_READ && !pass_ff) ? IDX_W'(rem_ff) : slot_ff;
   assign wr_key = state_ff == S_DONE && !reset &&
      (job_ff.opcode == OP_INSERT || (job_ff.opcode == OP_SET && !found_ff)) &&
      SZ_W'(count_ff) < size_ff && free_ff;
   assign wr_val = wr_key || (state_ff == S_DONE && !reset && found_ff &&
      (job_ff.opcode == OP_UPDATE || job_ff.opcode == OP_SET));
   assign waddr = wr_key ? freeslot_ff : hit_ff;

   // value is read beside the key and kept on a hit
   always_ff @(posedge clock) begin
      rkey_ff <= key_mem[raddr];
      rval_ff <= val_mem[raddr];
      if (wr_key) key_mem[waddr] <= job_ff.key;
      if (wr_val) val_mem[waddr] <= wval;
   end

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count disagrees with valid bits");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_full_ff)
      else $error("finished operation left no result");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_full_ff && !pop) |=> $stable(rsp_ff))
      else $error("waiting result changed");
endmodule

>>> src/string_key_linear_probe_hash_table.sv
// Top level of the string-key linear-probing hash table.
`timescale 1ns / 1ps
// Path: key hashing and hand-off in the front end, the queue, entry to the engine,
//   modulo, a slot read and check for every slot of the clamped table size, finish.
//   The engine takes a new word only once the last result has been popped;
//   the front end hashes the next word while the engine probes.
// Reset (synchronous): all slots empty, count 0, table_size 32, queues empty.
module string_key_linear_probe_hash_table import skh_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT,
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [OP_W-1:0] req_opcode,
   input  logic [KEY_W-1:0] req_key_chars,
   input  logic [DATA_W-1:0] req_data_value,
   output logic empty,
   input  logic pop,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [DATA_W-1:0] rsp_read_value,
   output logic [SIZE_W-1:0] rsp_occupied_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [SIZE_W-1:0] csr_table_size
);
   logic [SIZE_W-1:0] size_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;
   rsp_type rsp;

   // config taken any time; caller only writes while idle
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) size_ff <= SIZE_RESET;
      else if (csr_valid) size_ff <= csr_table_size;
   end

   skh_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .push, .full, .req_opcode, .req_key_chars, .req_data_value,
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   skh_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job));

   skh_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock, .reset, .table_size(size_ff), .job_valid(b_valid), .job_ready(b_ready),
      .job(b_job), .empty, .pop, .rsp);

   assign rsp_status = rsp.status;
   assign rsp_read_value = rsp.read_value;
   assign rsp_occupied_count = rsp.occupied_count;
endmodule
